/* design/dq_pkg.sv */
// Package for the deadline event queue: shared constants, codes and types.
// Used by the top level; depends on nothing.
`timescale 1ns / 1ps
package dq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 16;

  localparam logic [1:0] KIND_ADD     = 2'd0;
  localparam logic [1:0] KIND_ADVANCE = 2'd1;
  localparam logic [1:0] KIND_ABORT   = 2'd2;

  localparam logic [1:0] ACT_EXEC   = 2'd0;
  localparam logic [1:0] ACT_ABORT  = 2'd1;
  localparam logic [1:0] ACT_ACCEPT = 2'd2;
  localparam logic [1:0] ACT_REJECT = 2'd3;

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_SRCH_RD  = 10'b00_0000_0010,
    ST_SRCH_CHK = 10'b00_0000_0100,
    ST_SHIFT_RD = 10'b00_0000_1000,
    ST_SHIFT_WR = 10'b00_0001_0000,
    ST_INS      = 10'b00_0010_0000,
    ST_ADV_RD   = 10'b00_0100_0000,
    ST_ADV_CHK  = 10'b00_1000_0000,
    ST_ABT_RD   = 10'b01_0000_0000,
    ST_ABT_CHK  = 10'b10_0000_0000
  } state_t;

endpackage

/* design/dq_if.sv */
// Channel interfaces of the deadline event queue: command beats in, result beats out.
// No dependencies.
`timescale 1ns / 1ps
interface dq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] event_id;
  logic [63:0] exec_time;
  logic        stamp_add_time;
  logic        deletable;
  logic [31:0] elapsed;
  logic        force_req;

  modport source (output valid, kind, event_id, exec_time, stamp_add_time, deletable,
                  elapsed, force_req, input ready);
  modport sink (input valid, kind, event_id, exec_time, stamp_add_time, deletable,
                elapsed, force_req, output ready);
endinterface

interface dq_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_event_id;
  logic [1:0]  action;
  logic [63:0] now;
  logic [31:0] step_elapsed;
  logic        stamped;
  logic        last;

  modport source (output valid, out_event_id, action, now, step_elapsed, stamped, last,
                  input ready);
  modport sink (input valid, out_event_id, action, now, step_elapsed, stamped, last,
                output ready);
endinterface

/* design/dq_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
module dq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/deadline_event_queue.sv */
// Deadline event queue: ordered timer events kept in one RAM as a ring.
// A command with results hands its final beat out from the idle state before the next
// command is taken; one command is in work at a time.
// Reset (synchronous, active low) clears the state, the time, the count, the ring head
// and the pending and output valid flags.
`timescale 1ns / 1ps
module deadline_event_queue #(
  parameter int QUEUE_DEPTH = dq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = dq_pkg::ID_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  dq_in_if.sink    in_ch,
  dq_out_if.source out_ch
);

  // Each RAM word holds handle, due time, removable mark and cancelled mark.
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int E_W   = ID_BITS + 66;

  dq_pkg::state_t state_r, state_nxt;

  logic [63:0]        cur_time_r, cur_time_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]   keep_r, keep_nxt;

  // Command held for the duration of its work.
  logic [ID_BITS-1:0] c_id_r, c_id_nxt;
  logic [63:0]        c_due_r, c_due_nxt;
  logic               c_stamp_r, c_stamp_nxt;
  logic               c_del_r, c_del_nxt;
  logic [31:0]        c_el_r, c_el_nxt;
  logic               c_force_r, c_force_nxt;

  // A pending result is held back until we know whether another follows,
  // which is what decides its last flag.
  logic               pend_v_r, pend_v_nxt;
  logic [15:0]        pend_id_r, pend_id_nxt;
  logic [1:0]         pend_act_r, pend_act_nxt;
  logic [31:0]        pend_el_r, pend_el_nxt;
  logic               pend_st_r, pend_st_nxt;

  // Output register: the result beat being offered downstream.
  logic               o_v_r, o_v_nxt;
  logic [15:0]        o_id_r, o_id_nxt;
  logic [1:0]         o_act_r, o_act_nxt;
  logic [63:0]        o_now_r, o_now_nxt;
  logic [31:0]        o_el_r, o_el_nxt;
  logic               o_st_r, o_st_nxt;
  logic               o_last_r, o_last_nxt;

  logic               we;
  logic [IDX_W-1:0]   waddr, raddr;
  logic [E_W-1:0]     wdata, rdata;
  logic [ID_BITS-1:0] r_id;
  logic [63:0]        r_due;
  logic               r_rem, r_canc;

  logic               slot_free, can_push, emit, emit_last;
  logic [15:0]        r_id16;

  // Map a logical position (0 is the front) onto a RAM address in the ring.
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                            input logic [CNT_W-1:0] lpos);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(head) + (CNT_W + 1)'(lpos);
    if (s >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
      s = s - (CNT_W + 1)'(QUEUE_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  assign {r_id, r_due, r_rem, r_canc} = rdata;
  assign r_id16 = 16'(32'(r_id));
  assign raddr  = phys(head_r, idx_r);

  dq_ram #(.WIDTH(E_W), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign slot_free = !o_v_r || out_ch.ready;
  // A new result may enter the pending slot if that slot is empty or its
  // occupant can move into the output register this cycle.
  assign can_push  = !pend_v_r || slot_free;

  // A new command is taken only once the previous one has handed out its final beat.
  assign in_ch.ready = (state_r == dq_pkg::ST_IDLE) && !pend_v_r;

  always_comb begin
    state_nxt    = state_r;
    cur_time_nxt = cur_time_r;
    count_nxt    = count_r;
    head_nxt     = head_r;
    idx_nxt      = idx_r;
    pos_nxt      = pos_r;
    keep_nxt     = keep_r;
    c_id_nxt     = c_id_r;
    c_due_nxt    = c_due_r;
    c_stamp_nxt  = c_stamp_r;
    c_del_nxt    = c_del_r;
    c_el_nxt     = c_el_r;
    c_force_nxt  = c_force_r;
    pend_v_nxt   = pend_v_r;
    pend_id_nxt  = pend_id_r;
    pend_act_nxt = pend_act_r;
    pend_el_nxt  = pend_el_r;
    pend_st_nxt  = pend_st_r;
    we           = 1'b0;
    waddr        = phys(head_r, pos_r);
    wdata        = rdata;
    emit         = 1'b0;
    emit_last    = 1'b0;

    unique case (state_r)
      dq_pkg::ST_IDLE: begin
        if (pend_v_r) begin
          // Finish the previous command: its held result is the final one.
          if (slot_free) begin
            emit       = 1'b1;
            emit_last  = 1'b1;
            pend_v_nxt = 1'b0;
          end
        end else if (in_ch.valid) begin
          c_id_nxt    = ID_BITS'(in_ch.event_id);
          c_due_nxt   = in_ch.exec_time;
          c_stamp_nxt = in_ch.stamp_add_time;
          c_del_nxt   = in_ch.deletable;
          c_el_nxt    = in_ch.elapsed;
          c_force_nxt = in_ch.force_req;
          idx_nxt     = '0;
          keep_nxt    = '0;
          unique case (in_ch.kind)
            dq_pkg::KIND_ADD: begin
              if (count_r == CNT_W'(QUEUE_DEPTH)) begin
                pend_v_nxt   = 1'b1;
                pend_id_nxt  = 16'(32'(ID_BITS'(in_ch.event_id)));
                pend_act_nxt = dq_pkg::ACT_REJECT;
                pend_el_nxt  = '0;
                pend_st_nxt  = 1'b0;
              end else begin
                state_nxt = dq_pkg::ST_SRCH_RD;
              end
            end
            dq_pkg::KIND_ADVANCE: begin
              cur_time_nxt = cur_time_r + 64'(in_ch.elapsed);
              state_nxt    = dq_pkg::ST_ADV_RD;
            end
            dq_pkg::KIND_ABORT: begin
              state_nxt = dq_pkg::ST_ABT_RD;
            end
            default: begin
            end
          endcase
        end
      end

      // Insert: find the first entry due strictly later than the new one.
      dq_pkg::ST_SRCH_RD: begin
        if (idx_r == count_r) begin
          pos_nxt   = idx_r;
          state_nxt = dq_pkg::ST_INS;
        end else begin
          state_nxt = dq_pkg::ST_SRCH_CHK;
        end
      end
      dq_pkg::ST_SRCH_CHK: begin
        if (r_due <= c_due_r) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = dq_pkg::ST_SRCH_RD;
        end else begin
          pos_nxt   = idx_r;
          idx_nxt   = count_r - 1'b1;
          state_nxt = dq_pkg::ST_SHIFT_RD;
        end
      end

      // Move the tail back one place, last entry first.
      dq_pkg::ST_SHIFT_RD: begin
        state_nxt = dq_pkg::ST_SHIFT_WR;
      end
      dq_pkg::ST_SHIFT_WR: begin
        we    = 1'b1;
        waddr = phys(head_r, idx_r + 1'b1);
        wdata = rdata;
        if (idx_r == pos_r) begin
          state_nxt = dq_pkg::ST_INS;
        end else begin
          idx_nxt   = idx_r - 1'b1;
          state_nxt = dq_pkg::ST_SHIFT_RD;
        end
      end
      dq_pkg::ST_INS: begin
        we           = 1'b1;
        waddr        = phys(head_r, pos_r);
        wdata        = {c_id_r, c_due_r, c_del_r, 1'b0};
        count_nxt    = count_r + 1'b1;
        pend_v_nxt   = 1'b1;
        pend_id_nxt  = 16'(32'(c_id_r));
        pend_act_nxt = dq_pkg::ACT_ACCEPT;
        pend_el_nxt  = '0;
        pend_st_nxt  = c_stamp_r;
        state_nxt    = dq_pkg::ST_IDLE;
      end

      // Advance: pop from the front while the front entry is due.
      dq_pkg::ST_ADV_RD: begin
        if (count_r == '0) begin
          state_nxt = dq_pkg::ST_IDLE;
        end else begin
          state_nxt = dq_pkg::ST_ADV_CHK;
        end
      end
      dq_pkg::ST_ADV_CHK: begin
        if (r_due <= cur_time_r) begin
          if (can_push) begin
            emit         = pend_v_r;
            pend_v_nxt   = 1'b1;
            pend_id_nxt  = r_id16;
            pend_act_nxt = r_canc ? dq_pkg::ACT_ABORT : dq_pkg::ACT_EXEC;
            pend_el_nxt  = r_canc ? 32'd0 : c_el_r;
            pend_st_nxt  = 1'b0;
            head_nxt     = phys(head_r, CNT_W'(1));
            count_nxt    = count_r - 1'b1;
            state_nxt    = dq_pkg::ST_ADV_RD;
          end
        end else begin
          state_nxt = dq_pkg::ST_IDLE;
        end
      end

      // Abort-all: report every entry, compacting the survivors in place.
      dq_pkg::ST_ABT_RD: begin
        if (idx_r == count_r) begin
          count_nxt = keep_r;
          state_nxt = dq_pkg::ST_IDLE;
        end else begin
          state_nxt = dq_pkg::ST_ABT_CHK;
        end
      end
      dq_pkg::ST_ABT_CHK: begin
        if (can_push) begin
          emit         = pend_v_r;
          pend_v_nxt   = 1'b1;
          pend_id_nxt  = r_id16;
          pend_act_nxt = dq_pkg::ACT_ABORT;
          pend_el_nxt  = '0;
          pend_st_nxt  = 1'b0;
          if (!c_force_r && !r_rem) begin
            we       = 1'b1;
            waddr    = phys(head_r, keep_r);
            wdata    = {r_id, r_due, r_rem, 1'b1};
            keep_nxt = keep_r + 1'b1;
          end
          idx_nxt   = idx_r + 1'b1;
          state_nxt = dq_pkg::ST_ABT_RD;
        end
      end

      default: begin
        state_nxt = dq_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register loads from the pending slot.
  always_comb begin
    o_v_nxt    = o_v_r;
    o_id_nxt   = o_id_r;
    o_act_nxt  = o_act_r;
    o_now_nxt  = o_now_r;
    o_el_nxt   = o_el_r;
    o_st_nxt   = o_st_r;
    o_last_nxt = o_last_r;
    if (emit) begin
      o_v_nxt    = 1'b1;
      o_id_nxt   = pend_id_r;
      o_act_nxt  = pend_act_r;
      o_now_nxt  = cur_time_r;
      o_el_nxt   = pend_el_r;
      o_st_nxt   = pend_st_r;
      o_last_nxt = emit_last;
    end else if (out_ch.ready) begin
      o_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= dq_pkg::ST_IDLE;
      cur_time_r <= '0;
      count_r    <= '0;
      head_r     <= '0;
      pend_v_r   <= 1'b0;
      o_v_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cur_time_r <= cur_time_nxt;
      count_r    <= count_nxt;
      head_r     <= head_nxt;
      pend_v_r   <= pend_v_nxt;
      o_v_r      <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    keep_r     <= keep_nxt;
    c_id_r     <= c_id_nxt;
    c_due_r    <= c_due_nxt;
    c_stamp_r  <= c_stamp_nxt;
    c_del_r    <= c_del_nxt;
    c_el_r     <= c_el_nxt;
    c_force_r  <= c_force_nxt;
    pend_id_r  <= pend_id_nxt;
    pend_act_r <= pend_act_nxt;
    pend_el_r  <= pend_el_nxt;
    pend_st_r  <= pend_st_nxt;
    o_id_r     <= o_id_nxt;
    o_act_r    <= o_act_nxt;
    o_now_r    <= o_now_nxt;
    o_el_r     <= o_el_nxt;
    o_st_r     <= o_st_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign out_ch.valid        = o_v_r;
  assign out_ch.out_event_id = o_id_r;
  assign out_ch.action       = o_act_r;
  assign out_ch.now          = o_now_r;
  assign out_ch.step_elapsed = o_el_r;
  assign out_ch.stamped      = o_st_r;
  assign out_ch.last         = o_last_r;

endmodule
